// ===== hdl/hlfd_pkg.sv =====
// Shared types and constants for the header/length frame deframer.
package hlfd_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [7:0] HDR_OVERHEAD = 8'd4;
    localparam logic [7:0] DEPTH_BYTE   = 8'(BUF_DEPTH);

    typedef logic [BUF_AW-1:0] t_addr;
    typedef logic [BUF_AW:0]   t_fill;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic [7:0] function_code;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last_byte;
        logic       payload_empty;
    } t_result;

endpackage

// ===== hdl/hlfd_out_reg.sv =====
// Output register stage for result transfers.
module hlfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hlfd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output hlfd_pkg::t_result o_result,
    output logic              o_free
);

    logic              r_valid;
    hlfd_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hdl/header_length_frame_deframer_core.sv =====
// A byte transfer is taken every cycle while parsing; after the checksum byte
// transfer of a matching frame, each result is read from the buffer (ST_RD)
// and then loaded into the output register (ST_WR), waiting while the output is
// held off. The input is stalled until every result of a matching frame has
// been loaded, also the ST_EMPTY result of a checksum-only frame.
// Reset (synchronous, active low) clears the parser, sums and output valid;
// the payload buffer is not cleared and needs no clearing pass.
module header_length_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input stream: tdata = rx_byte[7:0]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // output stream: tdata = function_code[7:0], payload_byte[15:8],
    // byte_index[21:16], zero pad[23:22]; tuser = payload_empty
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser
);

    localparam logic CFG_HDR1 = 1'b0;
    localparam logic CFG_HDR2 = 1'b1;

    typedef enum logic [7:0] {
        ST_HEAD1 = 8'b0000_0001,
        ST_HEAD2 = 8'b0000_0010,
        ST_LEN   = 8'b0000_0100,
        ST_FUNC  = 8'b0000_1000,
        ST_DATA  = 8'b0001_0000,
        ST_RD    = 8'b0010_0000,
        ST_WR    = 8'b0100_0000,
        ST_EMPTY = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_hdr1, r_hdr2;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_func, n_func;
    hlfd_pkg::t_fill   r_fill, n_fill;
    logic [7:0]        r_sum, n_sum;
    hlfd_pkg::t_addr   r_rd_idx, n_rd_idx;
    hlfd_pkg::t_addr   r_last_idx, n_last_idx;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_mem [hlfd_pkg::BUF_DEPTH];

    logic              in_xfer;
    logic [7:0]        rx;
    logic [7:0]        dlen;
    logic              bad_len;
    hlfd_pkg::t_fill   fill_inc;
    logic [7:0]        check;
    logic              mem_we;
    logic              mem_re;
    logic              out_load;
    logic              out_free;
    logic              out_valid;
    hlfd_pkg::t_result out_d, out_q;

    assign o_s_axis_tready = (r_state == ST_HEAD1) || (r_state == ST_HEAD2) ||
                             (r_state == ST_LEN)   || (r_state == ST_FUNC)  ||
                             (r_state == ST_DATA);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign rx       = i_s_axis_tdata;

    assign dlen     = (r_len >= hlfd_pkg::HDR_OVERHEAD) ? r_len - hlfd_pkg::HDR_OVERHEAD : 8'd0;
    assign bad_len  = (dlen == 8'd0) || (dlen > hlfd_pkg::DEPTH_BYTE);
    assign fill_inc = r_fill + 1'b1;
    // checksum covers both headers, length, function and payload
    assign check    = r_hdr1 + r_hdr2 + r_len + r_func + r_sum;

    assign mem_we   = in_xfer && (r_state == ST_DATA) && !bad_len;
    assign mem_re   = (r_state == ST_RD);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_func     = r_func;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_rd_idx   = r_rd_idx;
        n_last_idx = r_last_idx;
        out_load   = 1'b0;
        out_d.function_code = r_func;
        out_d.payload_byte  = r_rd_data;
        out_d.byte_index    = 6'(r_rd_idx);
        out_d.last_byte     = (r_rd_idx == r_last_idx);
        out_d.payload_empty = 1'b0;

        case (r_state)
            ST_HEAD2: begin
                if (in_xfer) begin
                    n_state = (rx == r_hdr2) ? ST_LEN : ST_HEAD1;
                end
            end
            ST_LEN: begin
                if (in_xfer) begin
                    n_len   = rx;
                    n_state = ST_FUNC;
                end
            end
            ST_FUNC: begin
                if (in_xfer) begin
                    n_func  = rx;
                    n_fill  = '0;
                    n_sum   = 8'd0;
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (in_xfer) begin
                    if (bad_len) begin
                        n_state = ST_HEAD1;
                    end else begin
                        n_fill = fill_inc;
                        if (8'(fill_inc) < dlen) begin
                            n_sum = r_sum + rx;
                        end else begin
                            // this byte is the checksum, the one just stored
                            n_state = ST_HEAD1;
                            if (check == rx) begin
                                if (dlen == 8'd1) begin
                                    n_state = ST_EMPTY;
                                end else begin
                                    n_state    = ST_RD;
                                    n_rd_idx   = '0;
                                    n_last_idx = hlfd_pkg::t_addr'(dlen - 8'd2);
                                end
                            end
                        end
                    end
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_rd_idx == r_last_idx) begin
                        n_state = ST_HEAD1;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = ST_RD;
                    end
                end
            end
            ST_EMPTY: begin
                out_d.payload_byte  = 8'd0;
                out_d.byte_index    = 6'd0;
                out_d.last_byte     = 1'b1;
                out_d.payload_empty = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_HEAD1;
                end
            end
            default: begin
                // first-header hunt, also the fallback for stray codes
                n_state = ST_HEAD1;
                if (in_xfer && (rx == r_hdr1)) begin
                    n_state = ST_HEAD2;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HEAD1;
            r_hdr1     <= 8'd0;
            r_hdr2     <= 8'd0;
            r_len      <= 8'd0;
            r_func     <= 8'd0;
            r_fill     <= '0;
            r_sum      <= 8'd0;
            r_rd_idx   <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_func     <= n_func;
            r_fill     <= n_fill;
            r_sum      <= n_sum;
            r_rd_idx   <= n_rd_idx;
            r_last_idx <= n_last_idx;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_HDR1: r_hdr1 <= i_cfg_data;
                    CFG_HDR2: r_hdr2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload buffer: one write port (parser), one registered read port (emitter)
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[hlfd_pkg::t_addr'(r_fill)] <= rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    hlfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (out_d),
        .i_ready  (i_m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_q),
        .o_free   (out_free)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {2'b00, out_q.byte_index, out_q.payload_byte,
                              out_q.function_code};
    assign o_m_axis_tlast  = out_q.last_byte;
    assign o_m_axis_tuser  = out_q.payload_empty;

endmodule
